/* hdl/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants and register codes for the box transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_COLS  = NUM_AXES + 1;
  localparam int COEF_W    = 16;
  localparam int ROW_W     = NUM_COLS * COEF_W;
  localparam int OUT_W     = 34;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

/* hdl/aabb_affine_transform.sv */
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Axis-aligned box through the top three rows of an affine matrix.
// ----------------------------------------------------------------------------
// Takes one box per cycle unless the output side stalls, and returns its
// transformed bounds from the sum register; items pass in turn through the
// three-stage pipeline (multiply, per-column min/max, sum) whose registers
// each hold one item while the output side stalls. Instead of forming eight
// corners, each matrix entry picks the smaller and larger of its two products,
// which gives the same exact min and max. Matrix rows must be written through
// the cfg port only while no item is in flight; the block does not enforce it.
`default_nettype none

module aabb_affine_transform #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic clk,
  input  wire logic rst,

  input  wire logic s_axis_tvalid,
  output      logic s_axis_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, zero pad
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,

  output      logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z, zero pad
  output      logic [((6*aabb_pkg::OUT_W+7)/8)*8-1:0] m_axis_tdata,

  input  wire logic                           cfg_we,
  input  wire logic [aabb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [aabb_pkg::ROW_W-1:0]     cfg_data
);
  import aabb_pkg::*;

  localparam int PROD_W = COORD_WIDTH + COEF_W;
  localparam int TR_W   = COEF_W + FRAC_BITS;

  logic [ROW_W-1:0] row_coeffs [NUM_AXES];

  logic signed [COORD_WIDTH-1:0] lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] hi [NUM_AXES];
  logic signed [COEF_W-1:0]      coef [NUM_AXES][NUM_COLS];

  logic                    mul_valid, mul_ready;
  logic signed [PROD_W-1:0] p_lo [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] p_hi [NUM_AXES][NUM_AXES];
  logic signed [TR_W-1:0]   tr1 [NUM_AXES];

  logic                    mm_valid, mm_ready;
  logic signed [PROD_W-1:0] mn [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] mx [NUM_AXES][NUM_AXES];
  logic signed [TR_W-1:0]   tr2 [NUM_AXES];

  logic signed [OUT_W-1:0] out_lo [NUM_AXES];
  logic signed [OUT_W-1:0] out_hi [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        row_coeffs[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_X: row_coeffs[0] <= cfg_data;
        REG_ROW_Y: row_coeffs[1] <= cfg_data;
        REG_ROW_Z: row_coeffs[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lo[a] = s_axis_tdata[a*COORD_WIDTH +: COORD_WIDTH];
      hi[a] = s_axis_tdata[(a+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
      for (int j = 0; j < NUM_COLS; j++) begin
        coef[a][j] = row_coeffs[a][j*COEF_W +: COEF_W];
      end
    end
  end

  aabb_mul_stage #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .PROD_W     (PROD_W),
    .TR_W       (TR_W)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .lo       (lo),
    .hi       (hi),
    .coef     (coef),
    .out_valid(mul_valid),
    .out_ready(mul_ready),
    .p_lo     (p_lo),
    .p_hi     (p_hi),
    .tr       (tr1)
  );

  aabb_minmax_stage #(
    .PROD_W(PROD_W),
    .TR_W  (TR_W)
  ) u_minmax (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mul_valid),
    .in_ready (mul_ready),
    .p_lo     (p_lo),
    .p_hi     (p_hi),
    .tr_in    (tr1),
    .out_valid(mm_valid),
    .out_ready(mm_ready),
    .mn       (mn),
    .mx       (mx),
    .tr_out   (tr2)
  );

  aabb_sum_stage #(
    .PROD_W(PROD_W),
    .TR_W  (TR_W)
  ) u_sum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mm_valid),
    .in_ready (mm_ready),
    .mn       (mn),
    .mx       (mx),
    .tr       (tr2),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_lo   (out_lo),
    .out_hi   (out_hi)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      m_axis_tdata[a*OUT_W +: OUT_W]            = out_lo[a];
      m_axis_tdata[(a+NUM_AXES)*OUT_W +: OUT_W] = out_hi[a];
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !mul_valid && !mm_valid && !m_axis_tvalid)
    else $error("pipeline not empty after reset");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    mul_valid && mm_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("item accepted into a full stalled pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    mm_valid && m_axis_tvalid && !m_axis_tready |=> mm_valid)
    else $error("middle stage dropped an item during a stall");

endmodule

`default_nettype wire

/* hdl/aabb_mul_stage.sv */
// ----------------------------------------------------------------------------
// aabb_mul_stage
// First stage: each matrix coefficient times the low and the high coordinate
// of its column, plus the translation scaled to product precision.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_mul_stage #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8,
  parameter int PROD_W      = 32,
  parameter int TR_W        = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]       lo [aabb_pkg::NUM_AXES],
  input  wire logic signed [COORD_WIDTH-1:0]       hi [aabb_pkg::NUM_AXES],
  input  wire logic signed [aabb_pkg::COEF_W-1:0]
                             coef [aabb_pkg::NUM_AXES][aabb_pkg::NUM_COLS],
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [PROD_W-1:0]
                             p_lo [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  output      logic signed [PROD_W-1:0]
                             p_hi [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  output      logic signed [TR_W-1:0]              tr [aabb_pkg::NUM_AXES]
);
  import aabb_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          p_lo[a][j] <= PROD_W'(lo[j] * coef[a][j]);
          p_hi[a][j] <= PROD_W'(hi[j] * coef[a][j]);
        end
        tr[a] <= TR_W'(coef[a][NUM_AXES]) <<< FRAC_BITS;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/aabb_minmax_stage.sv */
// ----------------------------------------------------------------------------
// aabb_minmax_stage
// Second stage: per matrix entry, the smaller and larger of the two products.
// The min over all corners separates into one choice per column.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_minmax_stage #(
  parameter int PROD_W = 32,
  parameter int TR_W   = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic signed [PROD_W-1:0]
                             p_lo [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  input  wire logic signed [PROD_W-1:0]
                             p_hi [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  input  wire logic signed [TR_W-1:0] tr_in [aabb_pkg::NUM_AXES],
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic signed [PROD_W-1:0]
                             mn [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  output      logic signed [PROD_W-1:0]
                             mx [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  output      logic signed [TR_W-1:0] tr_out [aabb_pkg::NUM_AXES]
);
  import aabb_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          if (p_lo[a][j] < p_hi[a][j]) begin
            mn[a][j] <= p_lo[a][j];
            mx[a][j] <= p_hi[a][j];
          end else begin
            mn[a][j] <= p_hi[a][j];
            mx[a][j] <= p_lo[a][j];
          end
        end
        tr_out[a] <= tr_in[a];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/aabb_sum_stage.sv */
// ----------------------------------------------------------------------------
// aabb_sum_stage
// Last stage: sums the chosen products and the translation per axis into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_sum_stage #(
  parameter int PROD_W = 32,
  parameter int TR_W   = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic signed [PROD_W-1:0]
                             mn [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  input  wire logic signed [PROD_W-1:0]
                             mx [aabb_pkg::NUM_AXES][aabb_pkg::NUM_AXES],
  input  wire logic signed [TR_W-1:0] tr [aabb_pkg::NUM_AXES],
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic signed [aabb_pkg::OUT_W-1:0] out_lo [aabb_pkg::NUM_AXES],
  output      logic signed [aabb_pkg::OUT_W-1:0] out_hi [aabb_pkg::NUM_AXES]
);
  import aabb_pkg::*;

  localparam int SUM_W  = PROD_W + 2;
  localparam int EXT_A  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int EXT_W  = (EXT_A > TR_W + 1) ? EXT_A : TR_W + 1;

  logic signed [EXT_W-1:0] lo_sum [NUM_AXES];
  logic signed [EXT_W-1:0] hi_sum [NUM_AXES];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lo_sum[a] = EXT_W'(tr[a]);
      hi_sum[a] = EXT_W'(tr[a]);
      for (int j = 0; j < NUM_AXES; j++) begin
        lo_sum[a] = lo_sum[a] + EXT_W'(mn[a][j]);
        hi_sum[a] = hi_sum[a] + EXT_W'(mx[a][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        out_lo[a] <= lo_sum[a][OUT_W-1:0];
        out_hi[a] <= hi_sum[a][OUT_W-1:0];
      end
    end
  end

  // box corners stay ordered
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_order_chk
    a_ordered: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> out_lo[g] <= out_hi[g])
      else $error("transformed box min above max");
  end

endmodule

`default_nettype wire

/* tb/sv/aabb_affine_transform_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform_tb
// Self-checking bench for the affine box transform.
// ----------------------------------------------------------------------------
// Streams boxes through the block under several matrix settings: the zero
// matrix after reset, identity with translation and mirroring, the extreme
// coefficients and random matrices. Each box is predicted by transforming
// its eight corners exactly and taking the per-axis bounds. Results are
// checked in order, field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module aabb_affine_transform_tb;
  import aabb_pkg::*;

  localparam int COORD_W    = 16;
  localparam int FRAC_BITS  = 8;
  localparam int BOX_W      = ((6*COORD_W+7)/8)*8;
  localparam int RES_W      = ((6*OUT_W+7)/8)*8;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_LEN  = 230;
  localparam int IDLE_LIMIT = 4000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [COEF_W-1:0] Q_MIN  = 16'h8000;
  localparam logic [COEF_W-1:0] Q_MAX  = 16'h7FFF;
  localparam logic [COEF_W-1:0] Q_ONE  = 16'h0100;
  localparam logic [COEF_W-1:0] Q_NEG1 = 16'hFF00;
  localparam logic [COEF_W-1:0] Q_ZERO = 16'h0000;

  class box_scoreboard;
    logic [ROW_W-1:0] rows [NUM_AXES];
    logic [RES_W-1:0] bounds_q [$];
    int errors;

    function new();
      foreach (rows[a]) rows[a] = '0;
      errors = 0;
    endfunction

    function void set_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
      if (idx < NUM_AXES) rows[idx] = value;
    endfunction

    // exact bounds over the eight corners
    function void note_input(logic [BOX_W-1:0] box);
      longint lo [NUM_AXES];
      longint hi [NUM_AXES];
      longint p [NUM_AXES];
      longint mn [NUM_AXES];
      longint mx [NUM_AXES];
      longint t;
      logic [RES_W-1:0] word;
      for (int a = 0; a < NUM_AXES; a++) begin
        lo[a] = $signed(box[a*COORD_W +: COORD_W]);
        hi[a] = $signed(box[(a+NUM_AXES)*COORD_W +: COORD_W]);
      end
      for (int c = 0; c < 8; c++) begin
        for (int a = 0; a < NUM_AXES; a++) p[a] = c[a] ? hi[a] : lo[a];
        for (int a = 0; a < NUM_AXES; a++) begin
          t = longint'($signed(rows[a][3*COEF_W +: COEF_W])) * (longint'(1) << FRAC_BITS);
          for (int k = 0; k < NUM_AXES; k++)
            t += longint'($signed(rows[a][k*COEF_W +: COEF_W])) * p[k];
          if (c == 0 || t < mn[a]) mn[a] = t;
          if (c == 0 || t > mx[a]) mx[a] = t;
        end
      end
      word = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        word[a*OUT_W +: OUT_W]            = mn[a][OUT_W-1:0];
        word[(a+NUM_AXES)*OUT_W +: OUT_W] = mx[a][OUT_W-1:0];
      end
      bounds_q.push_back(word);
    endfunction

    function void check_result(logic [RES_W-1:0] got);
      string field_name [6] = '{"out_lo_x", "out_lo_y", "out_lo_z",
                                "out_hi_x", "out_hi_y", "out_hi_z"};
      logic [RES_W-1:0] want;
      if (bounds_q.size() == 0) begin
        $error("result item with no box waiting: %h", got);
        errors++;
        return;
      end
      want = bounds_q.pop_front();
      for (int f = 0; f < 6; f++) begin
        if (got[f*OUT_W +: OUT_W] !== want[f*OUT_W +: OUT_W]) begin
          $error("%s: expected %0d, got %0d", field_name[f],
                 $signed(want[f*OUT_W +: OUT_W]), $signed(got[f*OUT_W +: OUT_W]));
          errors++;
        end
      end
      if (got[RES_W-1:6*OUT_W] !== '0) begin
        $error("pad: expected 0, got %h", got[RES_W-1:6*OUT_W]);
        errors++;
      end
    endfunction

    function int pending();
      return bounds_q.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  logic [BOX_W-1:0] s_axis_tdata = '0;

  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z, zero pad
  logic [RES_W-1:0] m_axis_tdata;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_data  = '0;

  box_scoreboard sb = new();
  bit calm = 1'b0;

  aabb_affine_transform uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short idles, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COEF_W-1:0] rand_q();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return Q_MIN;
    if (r < 16) return Q_MAX;
    if (r < 20) return Q_ZERO;
    if (r < 24) return Q_ONE;
    if (r < 28) return Q_NEG1;
    return COEF_W'($urandom);
  endfunction

  function automatic logic [BOX_W-1:0] make_box(
    logic [COORD_W-1:0] lx, logic [COORD_W-1:0] ly, logic [COORD_W-1:0] lz,
    logic [COORD_W-1:0] hx, logic [COORD_W-1:0] hy, logic [COORD_W-1:0] hz);
    return {hz, hy, hx, lz, ly, lx};
  endfunction

  function automatic logic [ROW_W-1:0] make_row(
    logic [COEF_W-1:0] c0, logic [COEF_W-1:0] c1,
    logic [COEF_W-1:0] c2, logic [COEF_W-1:0] c3);
    return {c3, c2, c1, c0};
  endfunction

  task automatic send_box(input logic [BOX_W-1:0] box);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= box;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(box);
    if (!calm && $urandom_range(0, 99) < 30) begin
      gap = idle_len();
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_row(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_matrix(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                              input logic [ROW_W-1:0] rz);
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
  endtask

  task automatic send_extremes();
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
  endtask

  // result side: check accepted items, then choose next ready
  initial begin
    int stall_left;
    stall_left = 1;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_result(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        stall_left = idle_len();
        m_axis_tready <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid === 1'b1 && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [ROW_W-1:0] rx, ry, rz;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero matrix straight from reset
    send_extremes();
    send_box(BOX_W'({$urandom, $urandom, $urandom}));
    drain();

    // identity with translation on x and y, z mirrored; stray index ignored
    write_matrix(make_row(Q_ONE, Q_ZERO, Q_ZERO, 16'h0280),
                 make_row(Q_ZERO, Q_ONE, Q_ZERO, Q_NEG1 << 1),
                 make_row(Q_ZERO, Q_ZERO, Q_NEG1, Q_ZERO));
    write_reg(REG_UNUSED, '1);
    send_box(make_box(16'hFF00, 16'h0080, 16'h0100, 16'h0200, 16'h0300, 16'h0400));
    send_box(make_box(16'h0200, 16'h0080, 16'h0100, 16'hFF00, 16'h0300, 16'h0400));
    send_box(make_box(16'h1234, 16'h8765, 16'h0F0F, 16'h1234, 16'h8765, 16'h0F0F));
    send_extremes();
    drain();

    write_matrix({4{Q_MIN}}, {4{Q_MIN}}, {4{Q_MIN}});
    send_extremes();
    drain();

    write_matrix({4{Q_MAX}}, {4{Q_MAX}}, {4{Q_MAX}});
    send_extremes();
    send_box(make_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      rx = make_row(rand_q(), rand_q(), rand_q(), rand_q());
      ry = make_row(rand_q(), rand_q(), rand_q(), rand_q());
      rz = make_row(rand_q(), rand_q(), rand_q(), rand_q());
      write_matrix(rx, ry, rz);
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, {$urandom, $urandom});
      calm = (ph == 2);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (ph == 5 && i == PHASE_LEN/2) drain();
        send_box(make_box(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q()));
      end
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
